// ===== src/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// Conveyor speed controller package
// Shared state codes, key codes and the result word type.
// ----------------------------------------------------------------------------
package csc_pkg;

   // Drive machine state codes.
   localparam logic [1:0] DRV_STOPPED = 2'd0;
   localparam logic [1:0] DRV_SPEED1  = 2'd1;
   localparam logic [1:0] DRV_SPEED2  = 2'd2;
   localparam logic [1:0] DRV_EMERG   = 2'd3;

   // Measuring machine state codes.
   localparam logic [1:0] MEAS_LOW  = 2'd0;
   localparam logic [1:0] MEAS_HIGH = 2'd1;
   localparam logic [1:0] MEAS_SHOW = 2'd2;

   // Key codes.
   localparam logic [1:0] KEY_ZERO = 2'd1;
   localparam logic [1:0] KEY_ONE  = 2'd2;
   localparam logic [1:0] KEY_TWO  = 2'd3;

   // Motor output codes.
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_SPEED1 = 2'd1;
   localparam logic [1:0] MODE_SPEED2 = 2'd2;

   // Register index of pulses_per_cm and its reset value.
   localparam logic       REG_PULSES_PER_CM = 1'b0;
   localparam logic [7:0] PULSES_RESET      = 8'd10;

   localparam logic [15:0] SPEED_MAX = 16'hFFFF;

   // One result word.
   typedef struct packed {
      logic [1:0]  drive_mode;
      logic        emergency_shown;
      logic        speed_valid;
      logic [15:0] speed_cm_s;
      logic        window_restart;
   } rsp_word_type;

endpackage

// ===== src/conveyor_speed_controller.sv =====
// ----------------------------------------------------------------------------
// Conveyor speed controller
// Each taken control tick registers one result word into the output queue.
// Throughput: one tick per cycle while the two-word output queue before rsp_
// has room, except a tick that computes the speed, which holds off the next
// tick while the bit-serial divider shifts one quotient bit per cycle.
// Reset (synchronous, active high) stops the drive, clears the measurement and
// loads pulses_per_cm with 10.
// ----------------------------------------------------------------------------
module conveyor_speed_controller #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Control tick channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_key_code,
   input  logic        req_encoder_level,
   input  logic        req_window_elapsed,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_drive_mode,
   output logic        rsp_emergency_shown,
   output logic        rsp_speed_valid,
   output logic [15:0] rsp_speed_cm_s,
   output logic        rsp_window_restart,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import csc_pkg::*;

   localparam int CNT_WIDTH = $clog2(COUNT_WIDTH);
   localparam int EXT_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // Configuration and control state.
   logic [7:0]             ppc_ff;
   logic [1:0]             drive_ff, drive_in;
   logic [1:0]             meas_ff, meas_in;
   logic                   pend_ff, pend_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   level_ff, level_in;
   logic                   emerg_ff, emerg_in;
   logic [15:0]            speed_ff, speed_in;

   // Divider state.
   logic                   busy_ff;
   logic [CNT_WIDTH-1:0]   div_cnt_ff;
   logic [COUNT_WIDTH-1:0] div_q_ff;
   logic [7:0]             div_rem_ff;
   logic [7:0]             div_den_ff;

   // Output queue.
   rsp_word_type           slot0_ff, slot1_ff;
   logic [1:0]             fill_ff;

   logic                   req_fire, rsp_fire, cfg_write;
   logic                   div_start, restart_meas, measure_run;
   rsp_word_type           word_in;
   logic [8:0]             trial;
   logic                   trial_ge;
   logic [8:0]             trial_diff;
   logic [COUNT_WIDTH-1:0] quot_next;
   logic [EXT_WIDTH-1:0]   quot_ext;
   logic [15:0]            quot_sat;

   // Handshakes.
   assign req_ready  = !busy_ff && (fill_ff != 2'd2);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = (fill_ff != 2'd0);
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_PULSES_PER_CM);
   assign csr_prdata = (csr_paddr[2] == REG_PULSES_PER_CM) ? {24'd0, ppc_ff} : 32'd0;

   // Output fields come from the queue head.
   assign rsp_drive_mode      = slot0_ff.drive_mode;
   assign rsp_emergency_shown = slot0_ff.emergency_shown;
   assign rsp_speed_valid     = slot0_ff.speed_valid;
   assign rsp_speed_cm_s      = slot0_ff.speed_cm_s;
   assign rsp_window_restart  = slot0_ff.window_restart;

   // Next state of both machines for the tick on the input.
   always_comb begin
      drive_in     = drive_ff;
      meas_in      = meas_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      level_in     = level_ff;
      emerg_in     = emerg_ff;
      speed_in     = speed_ff;
      div_start    = 1'b0;
      restart_meas = 1'b0;
      measure_run  = 1'b0;
      word_in      = '0;

      case (drive_ff)
         DRV_STOPPED: begin
            if (req_key_code == KEY_ZERO) drive_in = DRV_SPEED1;
         end
         DRV_SPEED1, DRV_SPEED2: begin
            if (emerg_ff) drive_in = DRV_EMERG;
            else if (drive_ff == DRV_SPEED1 && req_key_code == KEY_ONE) drive_in = DRV_SPEED2;
            else if (drive_ff == DRV_SPEED2 && req_key_code == KEY_TWO) drive_in = DRV_SPEED1;
            else if (req_key_code == KEY_ZERO) drive_in = DRV_STOPPED;
            measure_run = 1'b1;
         end
         default: begin
            if (req_key_code == KEY_ZERO) begin
               emerg_in     = 1'b0;
               drive_in     = DRV_STOPPED;
               restart_meas = 1'b1;
            end
         end
      endcase

      // One step of the measuring machine while the belt was driven.
      if (measure_run) begin
         case (meas_ff)
            MEAS_LOW, MEAS_HIGH: begin
               if (req_window_elapsed) begin
                  pend_in = 1'b1;
               end else if (pend_ff) begin
                  meas_in = MEAS_SHOW;
                  if (ppc_ff == 8'd0) speed_in = SPEED_MAX;
                  else div_start = 1'b1;
               end else if (meas_ff == MEAS_LOW) begin
                  if (!level_ff) level_in = req_encoder_level;
                  else meas_in = MEAS_HIGH;
               end else begin
                  if (level_ff) begin
                     level_in = req_encoder_level;
                  end else begin
                     if (count_ff != {COUNT_WIDTH{1'b1}}) count_in = count_ff + 1'b1;
                     meas_in = MEAS_LOW;
                  end
               end
            end
            MEAS_SHOW: begin
               if (pend_ff && speed_ff == 16'd0) begin
                  emerg_in = 1'b1;
               end else if (pend_ff) begin
                  word_in.speed_valid = 1'b1;
                  word_in.speed_cm_s  = speed_ff;
                  restart_meas        = 1'b1;
               end
            end
            default: begin
               restart_meas = 1'b1;
            end
         endcase
      end

      // Measurement restart clears the window bookkeeping.
      if (restart_meas) begin
         pend_in  = 1'b0;
         speed_in = 16'd0;
         count_in = '0;
         level_in = 1'b0;
         meas_in  = MEAS_LOW;
         word_in.window_restart = 1'b1;
      end

      case (drive_in)
         DRV_SPEED1: word_in.drive_mode = MODE_SPEED1;
         DRV_SPEED2: word_in.drive_mode = MODE_SPEED2;
         default:    word_in.drive_mode = MODE_OFF;
      endcase
      word_in.emergency_shown = (drive_in == DRV_EMERG);
   end

   // One restoring divide step: next remainder and quotient bit.
   assign trial      = {div_rem_ff, div_q_ff[COUNT_WIDTH-1]};
   assign trial_ge   = (trial >= {1'b0, div_den_ff});
   assign trial_diff = trial - {1'b0, div_den_ff};
   assign quot_next  = {div_q_ff[COUNT_WIDTH-2:0], trial_ge};
   assign quot_ext   = EXT_WIDTH'(quot_next);
   assign quot_sat   = (quot_ext > EXT_WIDTH'(SPEED_MAX)) ? SPEED_MAX : quot_ext[15:0];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ppc_ff <= PULSES_RESET;
      end else if (cfg_write) begin
         ppc_ff <= csr_pwdata[7:0];
      end
   end

   // Machine state and the serial divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff   <= DRV_STOPPED;
         meas_ff    <= MEAS_LOW;
         pend_ff    <= 1'b0;
         count_ff   <= '0;
         level_ff   <= 1'b0;
         emerg_ff   <= 1'b0;
         speed_ff   <= 16'd0;
         busy_ff    <= 1'b0;
         div_cnt_ff <= '0;
      end else if (req_fire) begin
         drive_ff <= drive_in;
         meas_ff  <= meas_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         level_ff <= level_in;
         emerg_ff <= emerg_in;
         speed_ff <= speed_in;
         if (div_start) begin
            busy_ff    <= 1'b1;
            div_cnt_ff <= CNT_WIDTH'(COUNT_WIDTH - 1);
         end
      end else if (busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == '0) begin
            busy_ff  <= 1'b0;
            speed_ff <= quot_sat;
         end
      end
   end

   // Divider datapath: the dividend shifts out as the quotient shifts in.
   always_ff @(posedge clock) begin
      if (req_fire && div_start) begin
         div_q_ff   <= count_ff;
         div_rem_ff <= 8'd0;
         div_den_ff <= ppc_ff;
      end else if (busy_ff) begin
         div_q_ff   <= quot_next;
         div_rem_ff <= trial_ge ? trial_diff[7:0] : trial[7:0];
      end
   end

   // Two-word output queue; slot0 is the head.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         case ({req_fire, rsp_fire})
            2'b01:   fill_ff <= fill_ff - 1'b1;
            2'b10:   fill_ff <= fill_ff + 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({req_fire, rsp_fire})
         2'b01: begin
            slot0_ff <= slot1_ff;
         end
         2'b10: begin
            if (fill_ff == 2'd0) slot0_ff <= word_in;
            else slot1_ff <= word_in;
         end
         2'b11: begin
            if (fill_ff == 2'd1) begin
               slot0_ff <= word_in;
            end else begin
               slot0_ff <= slot1_ff;
               slot1_ff <= word_in;
            end
         end
         default: begin
            slot0_ff <= slot0_ff;
         end
      endcase
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Conveyor speed controller testbench
// Drives control ticks into the block and checks every result word against a
// cycle-free model of the drive and measuring machines. The run covers key
// handling and the zero-speed emergency and its clearing. It then runs
// randomized pulse trains under several divisor settings, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import csc_pkg::*;

   localparam int CW            = 16;
   localparam int RESET_CYCLES  = 11;
   localparam int DRAIN_CYCLES  = 24;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PRINT_LIMIT   = 40;
   localparam int PHASE_TICKS   = 188;
   localparam logic [1:0] KEY_NONE    = 2'd0;
   localparam logic [2:0] ADDR_PPC    = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_key_code = KEY_NONE;
   logic        req_encoder_level = 1'b0;
   logic        req_window_elapsed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [1:0]  rsp_drive_mode;
   logic        rsp_emergency_shown;
   logic        rsp_speed_valid;
   logic [15:0] rsp_speed_cm_s;
   logic        rsp_window_restart;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = ADDR_PPC;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   conveyor_speed_controller #(.COUNT_WIDTH(CW)) dut (.*);

   // Model state of the belt, as it stands after reset.
   logic [1:0]    drive_now   = DRV_STOPPED;
   logic [1:0]    meas_now    = MEAS_LOW;
   logic          window_due  = 1'b0;
   logic [CW-1:0] pulses      = '0;
   logic          level_seen  = 1'b0;
   logic          alarm       = 1'b0;
   logic [15:0]   speed_now   = 16'd0;
   logic [7:0]    divisor     = PULSES_RESET;

   // Result words owed by the block, oldest first.
   rsp_word_type belt_word_q[$];

   bit idle_on        = 1'b1;
   int stall_left     = 0;
   int fail_count     = 0;
   int ticks_sent     = 0;
   int words_checked  = 0;
   int reports_seen   = 0;
   int alarms_seen    = 0;
   int settings_used  = 0;
   int cycle_count    = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // The watchdog ends a run that hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Gap length for either side: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void clear_measure();
      window_due = 1'b0;
      speed_now  = 16'd0;
      pulses     = '0;
      level_seen = 1'b0;
      meas_now   = MEAS_LOW;
   endfunction

   // Advances the belt model by one control tick and returns its result word.
   function automatic rsp_word_type belt_tick(input logic [1:0] key, input logic lvl,
                                              input logic win);
      rsp_word_type w;
      logic [1:0]   start;
      w = '0;
      start = drive_now;
      case (start)
         DRV_STOPPED: begin
            if (key == KEY_ZERO) drive_now = DRV_SPEED1;
         end
         DRV_SPEED1, DRV_SPEED2: begin
            if (alarm) drive_now = DRV_EMERG;
            else if (start == DRV_SPEED1 && key == KEY_ONE) drive_now = DRV_SPEED2;
            else if (start == DRV_SPEED2 && key == KEY_TWO) drive_now = DRV_SPEED1;
            else if (key == KEY_ZERO) drive_now = DRV_STOPPED;
            // The measuring machine steps whenever the tick began while driving.
            case (meas_now)
               MEAS_LOW, MEAS_HIGH: begin
                  if (win) begin
                     window_due = 1'b1;
                  end else if (window_due) begin
                     speed_now = (divisor == 8'd0) ? SPEED_MAX : pulses / divisor;
                     meas_now = MEAS_SHOW;
                  end else if (meas_now == MEAS_LOW) begin
                     if (!level_seen) level_seen = lvl;
                     else meas_now = MEAS_HIGH;
                  end else if (level_seen) begin
                     level_seen = lvl;
                  end else begin
                     if (pulses != '1) pulses++;
                     meas_now = MEAS_LOW;
                  end
               end
               MEAS_SHOW: begin
                  if (window_due && speed_now == 16'd0) begin
                     alarm = 1'b1;
                  end else if (window_due) begin
                     w.speed_valid = 1'b1;
                     w.speed_cm_s = speed_now;
                     w.window_restart = 1'b1;
                     clear_measure();
                  end
               end
               default: begin
                  w.window_restart = 1'b1;
                  clear_measure();
               end
            endcase
         end
         default: begin
            if (key == KEY_ZERO) begin
               alarm = 1'b0;
               drive_now = DRV_STOPPED;
               w.window_restart = 1'b1;
               clear_measure();
            end
         end
      endcase
      w.drive_mode = (drive_now == DRV_SPEED1) ? MODE_SPEED1 :
                     (drive_now == DRV_SPEED2) ? MODE_SPEED2 : MODE_OFF;
      w.emergency_shown = (drive_now == DRV_EMERG);
      return w;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("mismatch at word %0d: %s got %0d want %0d", words_checked, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   // Sends one control tick, after a random gap, and records its result word.
   task automatic send_tick(input logic [1:0] key, input logic lvl, input logic win);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_key_code       <= key;
      req_encoder_level  <= lvl;
      req_window_elapsed <= win;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      belt_word_q.push_back(belt_tick(key, lvl, win));
      ticks_sent++;
   endtask

   // Holds the sender until every owed word has come back, then lets the block idle.
   task automatic settle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (belt_word_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      logic [31:0] data;
      data = $urandom();
      data[7:0] = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_PPC) begin
         divisor = value;
         settings_used++;
      end
   endtask

   // Reads pulses_per_cm back and compares it with the model.
   task automatic read_divisor;
      logic [31:0] data;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_PPC;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("pulses_per_cm readback", data, {24'd0, divisor});
   endtask

   // The result side stalls at random while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Each accepted result word is compared with the oldest owed word.
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (belt_word_q.size() == 0) begin
            flag_mismatch("result word with nothing owed", 32'd1, 32'd0);
         end else begin
            want = belt_word_q.pop_front();
            check_field("drive_mode", 32'(rsp_drive_mode), 32'(want.drive_mode));
            check_field("emergency_shown", 32'(rsp_emergency_shown),
                        32'(want.emergency_shown));
            check_field("speed_valid", 32'(rsp_speed_valid), 32'(want.speed_valid));
            check_field("speed_cm_s", 32'(rsp_speed_cm_s), 32'(want.speed_cm_s));
            check_field("window_restart", 32'(rsp_window_restart),
                        32'(want.window_restart));
            if (want.speed_valid) reports_seen++;
            if (want.emergency_shown) alarms_seen++;
            words_checked++;
         end
      end
   end

   // Reset value, a write to an unused index, then the divisor of one.
   task automatic test_register;
      read_divisor();
      csr_write(ADDR_UNUSED, 8'd77);
      read_divisor();
      csr_write(ADDR_PPC, 8'd1);
      read_divisor();
   endtask

   // Key handling in the stopped and both speed states; a window while stopped is ignored.
   task automatic test_drive_keys;
      send_tick(KEY_ONE, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b1);
      send_tick(KEY_ZERO, 1'b1, 1'b0);
      send_tick(KEY_ONE, 1'b0, 1'b0);
      send_tick(KEY_ONE, 1'b0, 1'b0);
      send_tick(KEY_TWO, 1'b0, 1'b0);
      send_tick(KEY_TWO, 1'b0, 1'b0);
      send_tick(KEY_ZERO, 1'b0, 1'b0);
   endtask

   // A window with no pulses gives speed zero, which raises emergency;
   // key zero then clears it and restarts the measurement.
   task automatic test_zero_speed_emergency;
      send_tick(KEY_ZERO, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b1);
      send_tick(KEY_NONE, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b1);
      send_tick(KEY_NONE, 1'b0, 1'b0);
      send_tick(KEY_ONE, 1'b0, 1'b0);
      send_tick(KEY_ZERO, 1'b0, 1'b0);
   endtask

   // One full encoder pulse, then a window, gives a report of one cm/s.
   task automatic test_first_report;
      send_tick(KEY_ZERO, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b1, 1'b0);
      send_tick(KEY_NONE, 1'b1, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b1);
      send_tick(KEY_NONE, 1'b0, 1'b0);
      send_tick(KEY_NONE, 1'b0, 1'b0);
   endtask

   // Random pulse trains and windows under several divisors. Keys mostly keep
   // the belt running; a small share of ticks is pure noise.
   task automatic test_random;
      logic [7:0] setting [6];
      logic [1:0] key;
      logic       lvl;
      logic       win;
      logic       cur_lvl;
      int         lvl_run;
      int         win_left;
      int         r;
      setting = '{8'd255, 8'd0, 8'd2, 8'd1, 8'd5, 8'd200};
      setting[4] = 8'($urandom_range(3, 8));
      cur_lvl = 1'b0;
      lvl_run = 0;
      win_left = 10;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         csr_write(ADDR_PPC, setting[phase]);
         read_divisor();
         idle_on = (phase != 3);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if ($urandom_range(0, 99) < 5) begin
               key = 2'($urandom_range(0, 3));
               lvl = 1'($urandom_range(0, 1));
               win = 1'($urandom_range(0, 1));
            end else begin
               if (lvl_run == 0) begin
                  cur_lvl = ~cur_lvl;
                  lvl_run = $urandom_range(1, 4);
               end
               lvl_run--;
               lvl = cur_lvl;
               win = 1'b0;
               if (win_left == 0) begin
                  win = 1'b1;
                  win_left = $urandom_range(6, 60);
               end else begin
                  win_left--;
               end
               r = $urandom_range(0, 99);
               if ((drive_now == DRV_STOPPED || drive_now == DRV_EMERG) && r < 35)
                  key = KEY_ZERO;
               else if (r < 4) key = KEY_ONE;
               else if (r < 8) key = KEY_TWO;
               else if (r < 10) key = KEY_ZERO;
               else key = KEY_NONE;
            end
            send_tick(key, lvl, win);
            // Midway the sender waits until every owed word is back.
            if (i == PHASE_TICKS / 2) settle();
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register();
      test_drive_keys();
      test_zero_speed_emergency();
      test_first_report();
      test_random();
      settle();
      $display("Run covered %0d control ticks and %0d result words under %0d divisor settings,",
               ticks_sent, words_checked, settings_used);
      $display("with %0d speed reports and %0d emergency words among them.",
               reports_seen, alarms_seen);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
